@@ rtl/kmc_pkg.sv @@
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types and constants for the keyed occurrence counter table.
// ----------------------------------------------------------------------------
package kmc_pkg;

    localparam int KEY_BYTES = 16;
    localparam int COUNT_W   = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Command codes carried in a request
    typedef enum logic [1:0] {
        CMD_COUNT  = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_RESET  = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    // One request as it travels down the hash chain
    typedef struct packed {
        cmd_t        command;
        logic [63:0] key_head;
        logic [63:0] key_tail;
    } item_t;

    // Engine status back to the top level
    typedef struct packed {
        logic take;
        logic clearing;
    } eng_ctrl_t;

    // Probe engine states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_UPDATE
    } eng_state_t;

endpackage

@@ rtl/keyed_occurrence_counter_table_unit.sv @@
// Path: a request passes the byte-per-cell hash chain and is taken by the engine from the
// last cell; it probes slots until a hit, a free slot or a full sweep, then registers
// the result. It takes a new request only once the last one is probed and its result
// registered, which waits while an earlier result is not yet accepted on m_ready.
// Reset: synchronous; afterwards a clearing pass over all TABLE_ENTRIES slots empties
// the slot valid memory, during which no request is accepted.
// ----------------------------------------------------------------------------
// keyed_occurrence_counter_table_unit
// Word counter table: a chain of hash cells feeds a linear-probing slot table
// holding keys of 16 bytes and saturating 32-bit counts.
// ----------------------------------------------------------------------------
module keyed_occurrence_counter_table_unit #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_command,
    input  logic [63:0]                  s_key_head,
    input  logic [63:0]                  s_key_tail,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [kmc_pkg::COUNT_W-1:0]  m_count_value,
    output logic                         m_key_found,
    output logic                         m_status
);
    import kmc_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);

    logic          cell_valid [KEY_BYTES];
    item_t         cell_item  [KEY_BYTES];
    logic [IW-1:0] cell_hash  [KEY_BYTES];
    eng_ctrl_t     ctrl;
    item_t         s_item;
    logic          advance;

    // Chain moves whenever its last stage is empty or being taken
    assign advance = !cell_valid[KEY_BYTES-1] || ctrl.take;
    assign s_ready = advance && !ctrl.clearing;

    assign s_item.command  = cmd_t'(s_command);
    assign s_item.key_head = s_key_head;
    assign s_item.key_tail = s_key_tail;

    // Hash chain, one key byte per cell
    for (genvar i = 0; i < KEY_BYTES; i++) begin : g_cell
        if (i == 0) begin : g_first
            kmc_hash_cell #(
                .TABLE_ENTRIES (TABLE_ENTRIES),
                .BYTE_IDX      (i)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .advance   (advance),
                .in_valid  (s_valid && !ctrl.clearing),
                .in_item   (s_item),
                .in_hash   ('0),
                .out_valid (cell_valid[i]),
                .out_item  (cell_item[i]),
                .out_hash  (cell_hash[i])
            );
        end else begin : g_next
            kmc_hash_cell #(
                .TABLE_ENTRIES (TABLE_ENTRIES),
                .BYTE_IDX      (i)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .advance   (advance),
                .in_valid  (cell_valid[i-1]),
                .in_item   (cell_item[i-1]),
                .in_hash   (cell_hash[i-1]),
                .out_valid (cell_valid[i]),
                .out_item  (cell_item[i]),
                .out_hash  (cell_hash[i])
            );
        end
    end

    // Slot table and result register
    kmc_probe_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (cell_valid[KEY_BYTES-1]),
        .in_item       (cell_item[KEY_BYTES-1]),
        .in_hash       (cell_hash[KEY_BYTES-1]),
        .ctrl          (ctrl),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_count_value (m_count_value),
        .m_key_found   (m_key_found),
        .m_status      (m_status)
    );

endmodule

@@ rtl/kmc_hash_cell.sv @@
// ----------------------------------------------------------------------------
// kmc_hash_cell
// One cell of the hash chain: folds one key byte into the running hash,
// h = (h * 31 + byte) mod TABLE_ENTRIES, and hands the request onward.
// ----------------------------------------------------------------------------
module kmc_hash_cell #(
    parameter int  TABLE_ENTRIES = 256,
    parameter int  BYTE_IDX      = 0,
    localparam int IW            = $clog2(TABLE_ENTRIES)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            in_valid,
    input  kmc_pkg::item_t  in_item,
    input  logic [IW-1:0]   in_hash,
    output logic            out_valid,
    output kmc_pkg::item_t  out_item,
    output logic [IW-1:0]   out_hash
);
    import kmc_pkg::*;

    // Width of h*31+byte, and number of conditional subtracts to reduce it
    localparam int XW    = $clog2(32 * TABLE_ENTRIES + 257);
    localparam int QW    = $clog2(32 + 256 / TABLE_ENTRIES);
    localparam int SHIFT = 56 - 8 * (BYTE_IDX % 8);

    logic          valid_reg;
    item_t         item_reg;
    logic [IW-1:0] hash_reg;
    logic [IW-1:0] hash_next;
    logic [63:0]   word;
    logic [7:0]    key_byte;

    // Pick this cell's byte
    assign word     = (BYTE_IDX < 8) ? in_item.key_head : in_item.key_tail;
    assign key_byte = 8'(word >> SHIFT);

    // Multiply-accumulate, then reduce by constant shifted subtracts
    always_comb begin
        logic [XW-1:0] x;
        logic [XW-1:0] lim;
        x   = (XW'(in_hash) << 5) - XW'(in_hash) + XW'(key_byte);
        lim = '0;
        for (int k = QW - 1; k >= 0; k--) begin
            lim = XW'(TABLE_ENTRIES) << k;
            if (x >= lim) begin
                x = x - lim;
            end
        end
        hash_next = IW'(x);
    end

    // Stage register, moves only when the chain advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg <= in_item;
            hash_reg <= hash_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_hash  = hash_reg;

endmodule

@@ rtl/kmc_probe_engine.sv @@
// ----------------------------------------------------------------------------
// kmc_probe_engine
// Slot table with linear probing: takes a hashed request from the chain,
// probes one slot per cycle, updates the count (count and reset commands) and registers the result.
// ----------------------------------------------------------------------------
module kmc_probe_engine #(
    parameter int  TABLE_ENTRIES = 256,
    localparam int IW            = $clog2(TABLE_ENTRIES)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  kmc_pkg::item_t               in_item,
    input  logic [IW-1:0]                in_hash,
    output kmc_pkg::eng_ctrl_t           ctrl,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [kmc_pkg::COUNT_W-1:0]  m_count_value,
    output logic                         m_key_found,
    output logic                         m_status
);
    import kmc_pkg::*;

    localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_ENTRIES - 1);

    // Slot storage
    logic [63:0]        head_mem  [TABLE_ENTRIES];
    logic [63:0]        tail_mem  [TABLE_ENTRIES];
    logic [COUNT_W-1:0] count_mem [TABLE_ENTRIES];
    logic               valid_mem [TABLE_ENTRIES];

    eng_state_t         state_reg, state_next;
    logic [IW-1:0]      pos_reg;
    logic [IW-1:0]      pos_next;
    logic [IW-1:0]      probe_cnt_reg;
    logic [IW-1:0]      clr_addr_reg;
    cmd_t               cmd_reg;
    logic [63:0]        head_reg;
    logic [63:0]        tail_reg;
    logic               found_reg;
    logic               free_reg;
    logic [COUNT_W-1:0] stored_cnt_reg;

    logic [63:0]        rd_head_reg;
    logic [63:0]        rd_tail_reg;
    logic [COUNT_W-1:0] rd_count_reg;
    logic               rd_valid_reg;

    logic               m_valid_reg;
    logic [COUNT_W-1:0] res_count_reg;
    logic               res_found_reg;
    logic               res_status_reg;

    logic               take;
    logic [IW-1:0]      rd_addr;
    logic               hit;
    logic               probe_done;
    logic               upd_fire;
    logic               valid_we;
    logic [IW-1:0]      valid_waddr;
    logic               valid_wdata;
    logic               key_we;
    logic               count_we;
    logic [COUNT_W-1:0] count_wdata;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] res_count;
    logic               res_status;

    // Probe compare on the registered slot read
    assign hit        = rd_valid_reg && (rd_head_reg == head_reg) && (rd_tail_reg == tail_reg);
    assign probe_done = !rd_valid_reg || hit || (probe_cnt_reg == LAST_SLOT);
    assign pos_next   = (pos_reg == LAST_SLOT) ? '0 : pos_reg + 1'b1;
    assign upd_fire   = (state_reg == ST_UPDATE) && (!m_valid_reg || m_ready);
    assign count_inc  = (stored_cnt_reg == COUNT_MAX) ? COUNT_MAX : stored_cnt_reg + 1'b1;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_addr_reg == LAST_SLOT) state_next = ST_IDLE;
            ST_IDLE:   if (in_valid) state_next = ST_PROBE;
            ST_PROBE:  if (probe_done) state_next = ST_UPDATE;
            ST_UPDATE: if (upd_fire) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // Control outputs
    always_comb begin
        take          = 1'b0;
        rd_addr       = pos_reg;
        ctrl.clearing = (state_reg == ST_CLEAR);
        unique case (state_reg)
            ST_IDLE: begin
                take    = in_valid;
                rd_addr = in_hash;
            end
            ST_PROBE: begin
                rd_addr = pos_next;
            end
            default: begin
                rd_addr = pos_reg;
            end
        endcase
        ctrl.take = take;
    end

    // Table update and result for the finished probe
    always_comb begin
        key_we      = 1'b0;
        count_we    = 1'b0;
        count_wdata = '0;
        res_count   = '0;
        res_status  = 1'b0;
        unique case (cmd_reg)
            CMD_COUNT: begin
                if (found_reg) begin
                    count_we    = upd_fire;
                    count_wdata = count_inc;
                    res_count   = count_inc;
                end else if (free_reg) begin
                    key_we      = upd_fire;
                    count_we    = upd_fire;
                    count_wdata = COUNT_W'(1);
                    res_count   = COUNT_W'(1);
                end else begin
                    res_status  = 1'b1;
                end
            end
            CMD_RESET: begin
                count_we = upd_fire && found_reg;
            end
            CMD_QUERY, CMD_UNUSED: begin
                res_count = found_reg ? stored_cnt_reg : '0;
            end
        endcase
        valid_we    = ctrl.clearing || key_we;
        valid_waddr = ctrl.clearing ? clr_addr_reg : pos_reg;
        valid_wdata = !ctrl.clearing;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (upd_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request and probe datapath
    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg       <= in_item.command;
            head_reg      <= in_item.key_head;
            tail_reg      <= in_item.key_tail;
            pos_reg       <= in_hash;
            probe_cnt_reg <= '0;
        end else if (state_reg == ST_PROBE) begin
            if (probe_done) begin
                found_reg      <= hit;
                free_reg       <= !rd_valid_reg;
                stored_cnt_reg <= rd_count_reg;
            end else begin
                pos_reg       <= pos_next;
                probe_cnt_reg <= probe_cnt_reg + 1'b1;
            end
        end
        if (upd_fire) begin
            res_count_reg  <= res_count;
            res_found_reg  <= found_reg;
            res_status_reg <= res_status;
        end
    end

    // Slot memories, registered reads
    always_ff @(posedge aclk) begin
        if (valid_we) begin
            valid_mem[valid_waddr] <= valid_wdata;
        end
        rd_valid_reg <= valid_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            head_mem[pos_reg] <= head_reg;
            tail_mem[pos_reg] <= tail_reg;
        end
        rd_head_reg <= head_mem[rd_addr];
        rd_tail_reg <= tail_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (count_we) begin
            count_mem[pos_reg] <= count_wdata;
        end
        rd_count_reg <= count_mem[rd_addr];
    end

    assign m_valid       = m_valid_reg;
    assign m_count_value = res_count_reg;
    assign m_key_found   = res_found_reg;
    assign m_status      = res_status_reg;

endmodule
